// File: rtl/evm_pkg.sv
// Shared types and constants of the ensemble majority vote block.
package evm_pkg;

    localparam int CLS_IN_W  = 4;
    localparam int SCORE_W   = 16;
    localparam int VOTE_W    = 7;
    localparam int SUM_W     = 22;
    localparam int TOTAL_W   = 20;
    localparam int NUM_CFG_W = 5;

    localparam logic [VOTE_W-1:0]    VOTE_MAX   = 7'd127;
    localparam logic [SUM_W-1:0]     SUM_MAX    = 22'd4194303;
    localparam logic [TOTAL_W-1:0]   TOTAL_MAX  = 20'd1048575;
    localparam logic [SUM_W-1:0]     START_SIZE = 22'd2000;
    localparam logic [NUM_CFG_W-1:0] NUM_RESET  = 5'd16;

    typedef struct packed {
        logic [VOTE_W-1:0] votes;
        logic [SUM_W-1:0]  score;
        logic [SUM_W-1:0]  size;
    } t_class_rec;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } t_store_ctl;

    typedef enum logic {
        UOP_ACC,
        UOP_CMP
    } t_unit_op;

endpackage

// File: rtl/evm_if.sv
// Handshake channels for member votes and pattern results.
interface evm_vote_if import evm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CLS_IN_W-1:0] predicted_class;
    logic [SCORE_W-1:0]  member_score;
    logic [SCORE_W-1:0]  member_size;
    logic [CLS_IN_W-1:0] true_label;
    logic                last_member;

    modport source (output valid, predicted_class, member_score, member_size,
                    true_label, last_member, input ready);
    modport sink (input valid, predicted_class, member_score, member_size,
                  true_label, last_member, output ready);
endinterface

interface evm_result_if import evm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CLS_IN_W-1:0] ensemble_class;
    logic                is_correct;
    logic [TOTAL_W-1:0]  correct_total;
    logic [TOTAL_W-1:0]  wrong_total;

    modport source (output valid, ensemble_class, is_correct, correct_total,
                    wrong_total, input ready);
    modport sink (input valid, ensemble_class, is_correct, correct_total,
                  wrong_total, output ready);
endinterface

// File: rtl/ensemble_majority_vote_tiebreak_core.sv
// Top level of the ensemble majority vote block with score and size tie breakers.
//
// Each transfer on i_vote carries one ensemble member's vote for the current pattern.
// A vote is accepted, its class record read, then written back with saturating sums.
// The vote flagged last_member then scans n = min(num_classes, MAX_CLASSES) classes
// through the shared compare unit, one class per cycle; the scan ends once no read is
// pending, then the finish state loads the result register.
// The per-class record memory has one read and one write port; its reads are
// registered, so each compare comes in the cycle after its issue.
// i_vote.ready is high only while no vote is in progress.
// One transfer on o_result follows each last vote: the winner, a correct flag, and
// saturating correct and wrong totals. The result waits in an output register while
// the receiver stalls; a new vote may be taken meanwhile, and a second result
// holds the sequencer until the first transfer completes.
// Synchronous reset clears the class records, the totals, and the output valid flag,
// and sets num_classes to 16. The class records also clear after every result.
// num_classes is written through i_cfg_wr_en and i_cfg_wr_data; the user must write
// it only while the block is idle, and the block does not enforce this.
module ensemble_majority_vote_tiebreak_core import evm_pkg::*; #(
    parameter int MAX_CLASSES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [NUM_CFG_W-1:0] i_cfg_wr_data,
    evm_vote_if.sink             i_vote,
    evm_result_if.source         o_result
);

    localparam int CLS_W = $clog2(MAX_CLASSES);
    localparam int CNT_W = $clog2(MAX_CLASSES + 1);
    localparam int XW    = (CNT_W > NUM_CFG_W) ? CNT_W : NUM_CFG_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_WR,
        S_SCAN,
        S_FIN
    } t_state;

    t_state               r_state;
    logic [CLS_IN_W-1:0]  r_cls;
    logic [SCORE_W-1:0]   r_score;
    logic [SCORE_W-1:0]   r_size;
    logic [CLS_IN_W-1:0]  r_label;
    logic                 r_last;
    logic [NUM_CFG_W-1:0] r_num;
    logic [XW-1:0]        r_k;
    logic                 r_pend;
    logic [CLS_W-1:0]     r_pidx;
    logic                 r_first;
    logic [CLS_W-1:0]     r_best;
    logic [VOTE_W-1:0]    r_best_votes;
    logic [SUM_W-1:0]     r_best_score;
    logic [SUM_W-1:0]     r_best_size;
    logic [TOTAL_W-1:0]   r_right;
    logic [TOTAL_W-1:0]   r_miss;
    logic                 r_out_vld;
    logic [CLS_IN_W-1:0]  r_out_class;
    logic                 r_out_ok;

    t_store_ctl         store_ctl;
    logic [CLS_W-1:0]   rd_addr;
    logic [CLS_W-1:0]   wr_addr;
    t_class_rec         rd_data;
    t_class_rec         sum_rec;
    t_unit_op           unit_op;
    logic               win;
    logic [XW-1:0]      count;
    logic [XW-1:0]      cls_x;
    logic [XW-1:0]      in_cls_x;
    logic [XW-1:0]      best_x;
    logic               in_cls_ok;
    logic               issue;
    logic               load;
    logic               ok;
    logic               in_xfer;
    logic [TOTAL_W-1:0] n_right;
    logic [TOTAL_W-1:0] n_miss;

    always_comb begin
        count     = (XW'(r_num) > XW'(MAX_CLASSES)) ? XW'(MAX_CLASSES) : XW'(r_num);
        cls_x     = XW'(r_cls);
        in_cls_x  = XW'(i_vote.predicted_class);
        best_x    = XW'(r_best);
        in_cls_ok = in_cls_x < XW'(MAX_CLASSES);
        in_xfer   = i_vote.valid && i_vote.ready;
        issue     = (r_state == S_SCAN) && (r_k < count);
        load      = (r_state == S_FIN) && (!r_out_vld || o_result.ready);
        ok        = best_x == XW'(r_label);
        n_right   = r_right;
        n_miss    = r_miss;
        if (ok) begin
            n_right = (r_right == TOTAL_MAX) ? TOTAL_MAX : r_right + 1'b1;
        end else begin
            n_miss = (r_miss == TOTAL_MAX) ? TOTAL_MAX : r_miss + 1'b1;
        end
        store_ctl.rd_en = (r_state == S_RD) || issue;
        store_ctl.wr_en = (r_state == S_WR);
        store_ctl.clr   = load;
        rd_addr = (r_state == S_RD) ? cls_x[CLS_W-1:0] : r_k[CLS_W-1:0];
        wr_addr = cls_x[CLS_W-1:0];
        unit_op = (r_state == S_WR) ? UOP_ACC : UOP_CMP;
    end

    evm_store #(
        .MAX_CLASSES(MAX_CLASSES)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (store_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_data (sum_rec),
        .o_rd_data (rd_data)
    );

    evm_unit u_unit (
        .i_op         (unit_op),
        .i_rec        (rd_data),
        .i_score      (r_score),
        .i_size       (r_size),
        .i_first      (r_first),
        .i_best_votes (r_best_votes),
        .i_best_score (r_best_score),
        .i_best_size  (r_best_size),
        .o_sum        (sum_rec),
        .o_win        (win)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_num     <= NUM_RESET;
            r_right   <= '0;
            r_miss    <= '0;
            r_out_vld <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_num <= i_cfg_wr_data;
            end
            if (o_result.valid && o_result.ready && !load) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_cls   <= i_vote.predicted_class;
                        r_score <= i_vote.member_score;
                        r_size  <= i_vote.member_size;
                        r_label <= i_vote.true_label;
                        r_last  <= i_vote.last_member;
                        r_k          <= '0;
                        r_pend       <= 1'b0;
                        r_first      <= 1'b1;
                        r_best       <= '0;
                        r_best_score <= '0;
                        r_best_size  <= START_SIZE;
                        if (in_cls_ok) begin
                            r_state <= S_RD;
                        end else if (i_vote.last_member) begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_state <= r_last ? S_SCAN : S_IDLE;
                end
                S_SCAN: begin
                    r_pend <= issue;
                    r_pidx <= r_k[CLS_W-1:0];
                    if (issue) begin
                        r_k <= r_k + 1'b1;
                    end
                    if (r_pend) begin
                        r_first <= 1'b0;
                        if (win || r_first) begin
                            r_best_votes <= rd_data.votes;
                        end
                        if (win) begin
                            r_best       <= r_pidx;
                            r_best_score <= rd_data.score;
                            r_best_size  <= rd_data.size;
                        end
                    end
                    if (!issue && !r_pend) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (load) begin
                        r_out_vld   <= 1'b1;
                        r_out_class <= best_x[CLS_IN_W-1:0];
                        r_out_ok    <= ok;
                        r_right     <= n_right;
                        r_miss      <= n_miss;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_vote.ready            = (r_state == S_IDLE);
    assign o_result.valid          = r_out_vld;
    assign o_result.ensemble_class = r_out_class;
    assign o_result.is_correct     = r_out_ok;
    assign o_result.correct_total  = r_right;
    assign o_result.wrong_total    = r_miss;

endmodule

// File: rtl/evm_store.sv
// Per-class vote record memory with valid bits that all clear together on a clear request.
module evm_store import evm_pkg::*; #(
    parameter int MAX_CLASSES = 16,
    localparam int CLS_W = $clog2(MAX_CLASSES)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_store_ctl       i_ctl,
    input  logic [CLS_W-1:0] i_rd_addr,
    input  logic [CLS_W-1:0] i_wr_addr,
    input  t_class_rec       i_wr_data,
    output t_class_rec       o_rd_data
);

    t_class_rec             mem [MAX_CLASSES];
    logic [MAX_CLASSES-1:0] r_valid;
    t_class_rec             r_rd_data;
    logic                   r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data  <= mem[i_rd_addr];
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.clr) begin
            r_valid <= '0;
        end else if (i_ctl.wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// File: rtl/evm_unit.sv
// Shared unit: saturating vote accumulation or winner comparison.
module evm_unit import evm_pkg::*; (
    input  t_unit_op           i_op,
    input  t_class_rec         i_rec,
    input  logic [SCORE_W-1:0] i_score,
    input  logic [SCORE_W-1:0] i_size,
    input  logic               i_first,
    input  logic [VOTE_W-1:0]  i_best_votes,
    input  logic [SUM_W-1:0]   i_best_score,
    input  logic [SUM_W-1:0]   i_best_size,
    output t_class_rec         o_sum,
    output logic               o_win
);

    logic [SUM_W:0]    score_add;
    logic [SUM_W:0]    size_add;
    logic [VOTE_W-1:0] ref_votes;

    always_comb begin
        score_add = {1'b0, i_rec.score} + (SUM_W + 1)'(i_score);
        size_add  = {1'b0, i_rec.size} + (SUM_W + 1)'(i_size);
        ref_votes = i_first ? i_rec.votes : i_best_votes;
        o_sum     = i_rec;
        o_win     = 1'b0;
        unique case (i_op)
            UOP_ACC: begin
                o_sum.votes = (i_rec.votes == VOTE_MAX) ? VOTE_MAX : i_rec.votes + 1'b1;
                o_sum.score = score_add[SUM_W] ? SUM_MAX : score_add[SUM_W-1:0];
                o_sum.size  = size_add[SUM_W] ? SUM_MAX : size_add[SUM_W-1:0];
            end
            UOP_CMP: begin
                if (i_rec.votes > ref_votes) begin
                    o_win = 1'b1;
                end else if (i_rec.votes == ref_votes) begin
                    o_win = (i_rec.score > i_best_score) ||
                            ((i_rec.score == i_best_score) && (i_rec.size < i_best_size));
                end
            end
            default: o_win = 1'b0;
        endcase
    end

endmodule

// File: dv/vote_tally_checker.sv
`timescale 1ns / 1ps
// Checker that tallies member votes, predicts each pattern's verdict and compares results.
module vote_tally_checker import evm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [NUM_CFG_W-1:0] i_cfg_wr_data,
    evm_vote_if                  i_vote,
    evm_result_if                i_result,
    output int                   o_fail_count,
    output int                   o_verdicts_due,
    output int                   o_verdicts_seen
);

    localparam int NUM_CLS = 16;

    typedef struct packed {
        logic [CLS_IN_W-1:0] ensemble_class;
        logic                is_correct;
        logic [TOTAL_W-1:0]  correct_total;
        logic [TOTAL_W-1:0]  wrong_total;
    } t_verdict;

    logic [VOTE_W-1:0]    tally_votes [NUM_CLS];
    logic [SUM_W-1:0]     tally_score [NUM_CLS];
    logic [SUM_W-1:0]     tally_size  [NUM_CLS];
    logic [TOTAL_W-1:0]   right_total;
    logic [TOTAL_W-1:0]   miss_total;
    logic [NUM_CFG_W-1:0] class_count;
    t_verdict             verdict_queue [$];

    initial begin
        o_fail_count    = 0;
        o_verdicts_due  = 0;
        o_verdicts_seen = 0;
    end

    function automatic logic [31:0] sat_add(input logic [31:0] a, b, lim);
        logic [31:0] s;
        s = a + b;
        return (s > lim) ? lim : s;
    endfunction

    function automatic void clear_tally();
        for (int k = 0; k < NUM_CLS; k++) begin
            tally_votes[k] = '0;
            tally_score[k] = '0;
            tally_size[k]  = '0;
        end
    endfunction

    function automatic logic [CLS_IN_W-1:0] pick_winner();
        int               scan_len;
        int               best;
        logic [SUM_W-1:0] best_score;
        logic [SUM_W-1:0] best_size;
        logic             win;
        scan_len   = (class_count > NUM_CLS) ? NUM_CLS : int'(class_count);
        best       = 0;
        best_score = '0;
        best_size  = START_SIZE;
        for (int k = 0; k < scan_len; k++) begin
            win = 1'b0;
            if (tally_votes[k] > tally_votes[best]) begin
                win = 1'b1;
            end else if (tally_votes[k] == tally_votes[best]) begin
                if (tally_score[k] > best_score) begin
                    win = 1'b1;
                end else if (tally_score[k] == best_score && tally_size[k] < best_size) begin
                    win = 1'b1;
                end
            end
            if (win) begin
                best       = k;
                best_score = tally_score[k];
                best_size  = tally_size[k];
            end
        end
        return best[CLS_IN_W-1:0];
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_verdict want;
        int       idx;
        if (!i_rst_n) begin
            clear_tally();
            right_total = '0;
            miss_total  = '0;
            class_count = NUM_RESET;
            verdict_queue.delete();
        end else begin
            if (i_cfg_wr_en) begin
                class_count = i_cfg_wr_data;
            end
            if (i_result.valid && i_result.ready) begin
                o_verdicts_seen++;
                if (verdict_queue.size() == 0) begin
                    $error("result transfer with no verdict expected: class %0d",
                           i_result.ensemble_class);
                    o_fail_count++;
                end else begin
                    want = verdict_queue.pop_front();
                    check_field("ensemble_class", 32'(want.ensemble_class),
                                32'(i_result.ensemble_class));
                    check_field("is_correct", 32'(want.is_correct),
                                32'(i_result.is_correct));
                    check_field("correct_total", 32'(want.correct_total),
                                32'(i_result.correct_total));
                    check_field("wrong_total", 32'(want.wrong_total),
                                32'(i_result.wrong_total));
                end
            end
            if (i_vote.valid && i_vote.ready) begin
                idx = int'(i_vote.predicted_class);
                tally_votes[idx] = VOTE_W'(sat_add(32'(tally_votes[idx]), 32'd1,
                                                   32'(VOTE_MAX)));
                tally_score[idx] = SUM_W'(sat_add(32'(tally_score[idx]),
                                                  32'(i_vote.member_score), 32'(SUM_MAX)));
                tally_size[idx]  = SUM_W'(sat_add(32'(tally_size[idx]),
                                                  32'(i_vote.member_size), 32'(SUM_MAX)));
                if (i_vote.last_member) begin
                    want.ensemble_class = pick_winner();
                    want.is_correct     = (want.ensemble_class == i_vote.true_label);
                    if (want.is_correct) begin
                        right_total = TOTAL_W'(sat_add(32'(right_total), 32'd1,
                                                       32'(TOTAL_MAX)));
                    end else begin
                        miss_total = TOTAL_W'(sat_add(32'(miss_total), 32'd1,
                                                      32'(TOTAL_MAX)));
                    end
                    want.correct_total = right_total;
                    want.wrong_total   = miss_total;
                    verdict_queue.push_back(want);
                    clear_tally();
                end
            end
        end
        o_verdicts_due = verdict_queue.size();
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, vote stimulus, result back-pressure and the final verdict.
module tb;
    import evm_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_VOTES   = 200;

    typedef enum int {
        RDY_OPEN,
        RDY_COIN,
        RDY_HOLD,
        RDY_TOGGLE
    } t_ready_mode;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_wr_en;
    logic [NUM_CFG_W-1:0] cfg_wr_data;
    int                   fail_count;
    int                   verdicts_due;
    int                   verdicts_seen;
    int                   votes_sent;
    int                   settings_used;
    int                   burst_left;

    evm_vote_if   vote_ch ();
    evm_result_if result_ch ();

    ensemble_majority_vote_tiebreak_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_vote        (vote_ch),
        .o_result      (result_ch)
    );

    vote_tally_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_vote          (vote_ch),
        .i_result        (result_ch),
        .o_fail_count    (fail_count),
        .o_verdicts_due  (verdicts_due),
        .o_verdicts_seen (verdicts_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        t_ready_mode mode;
        int          span;
        result_ch.ready <= 1'b0;
        @(negedge i_clk);
        forever begin
            mode = t_ready_mode'($urandom_range(0, 3));
            span = $urandom_range(1, 40);
            repeat (span) begin
                case (mode)
                    RDY_OPEN: result_ch.ready <= 1'b1;
                    RDY_COIN: result_ch.ready <= 1'($urandom_range(0, 1));
                    RDY_HOLD: result_ch.ready <= 1'b0;
                    default:  result_ch.ready <= ~result_ch.ready;
                endcase
                @(negedge i_clk);
            end
        end
    end

    task automatic send_vote(input logic [CLS_IN_W-1:0] cls, input logic [SCORE_W-1:0] score,
                             input logic [SCORE_W-1:0] size, input logic [CLS_IN_W-1:0] label,
                             input logic last);
        vote_ch.valid           <= 1'b1;
        vote_ch.predicted_class <= cls;
        vote_ch.member_score    <= score;
        vote_ch.member_size     <= size;
        vote_ch.true_label      <= label;
        vote_ch.last_member     <= last;
        do @(posedge i_clk); while (!vote_ch.ready);
        votes_sent++;
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            vote_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    task automatic wait_drained();
        if (vote_ch.valid) begin
            vote_ch.valid <= 1'b0;
        end
        burst_left = 0;
        while (verdicts_due != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_class_count(input logic [NUM_CFG_W-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic send_random_pattern(input logic [NUM_CFG_W-1:0] nc);
        int                  kind;
        int                  len;
        int                  top_cls;
        logic                tight;
        logic [CLS_IN_W-1:0] cls;
        logic [CLS_IN_W-1:0] lead;
        logic [CLS_IN_W-1:0] label;
        logic [SCORE_W-1:0]  score;
        logic [SCORE_W-1:0]  size;
        kind    = $urandom_range(0, 99);
        top_cls = (nc >= 1 && nc <= 16) ? int'(nc) - 1 : 15;
        if ($urandom_range(0, 7) == 0) begin
            top_cls = 15;
        end
        if (kind < 1) begin
            lead  = 4'($urandom_range(0, 15));
            label = 4'($urandom_range(0, 15));
            len   = $urandom_range(128, 136);
            for (int m = 0; m < len; m++) begin
                send_vote(lead, 16'hFFFF, 16'($urandom), label, m == len - 1);
            end
        end else if (kind < 90) begin
            tight = 1'($urandom_range(0, 1));
            len   = $urandom_range(1, 8);
            lead  = 4'($urandom_range(0, top_cls));
            label = $urandom_range(0, 1) ? lead : 4'($urandom_range(0, 15));
            for (int m = 0; m < len; m++) begin
                cls   = (m == 0) ? lead : 4'($urandom_range(0, top_cls));
                score = tight ? 16'($urandom_range(0, 2)) : 16'($urandom);
                if (!tight) begin
                    size = 16'($urandom);
                end else if ($urandom_range(0, 1)) begin
                    size = 16'($urandom_range(0, 2));
                end else begin
                    size = 16'($urandom_range(1998, 2001));
                end
                send_vote(cls, score, size, label, m == len - 1);
            end
        end else begin
            len = $urandom_range(1, 4);
            for (int m = 0; m < len; m++) begin
                send_vote(4'($urandom), 16'($urandom), 16'($urandom), 4'($urandom),
                          1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic run_phase(input logic [NUM_CFG_W-1:0] nc);
        int start;
        start = votes_sent;
        while (votes_sent - start < PHASE_VOTES) begin
            send_random_pattern(nc);
        end
    endtask

    initial begin
        logic [NUM_CFG_W-1:0] counts [$];
        votes_sent    = 0;
        settings_used = 1;
        burst_left    = 0;
        i_rst_n                 <= 1'b0;
        cfg_wr_en               <= 1'b0;
        cfg_wr_data             <= '0;
        vote_ch.valid           <= 1'b0;
        vote_ch.predicted_class <= '0;
        vote_ch.member_score    <= '0;
        vote_ch.member_size     <= '0;
        vote_ch.true_label      <= '0;
        vote_ch.last_member     <= 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_vote(4'd0, 16'd0, 16'd0, 4'd0, 1'b1);
        send_vote(4'd15, 16'hFFFF, 16'hFFFF, 4'd15, 1'b1);
        send_vote(4'd3, 16'd10, 16'd5, 4'd3, 1'b0);
        send_vote(4'd7, 16'd20, 16'd5, 4'd7, 1'b1);
        send_vote(4'd4, 16'd10, 16'd9, 4'd4, 1'b0);
        send_vote(4'd9, 16'd10, 16'd8, 4'd4, 1'b1);
        send_vote(4'd0, 16'd0, 16'd2000, 4'd1, 1'b0);
        send_vote(4'd1, 16'd0, 16'd1999, 4'd1, 1'b1);
        send_vote(4'd0, 16'd0, 16'd2000, 4'd0, 1'b1);
        send_vote(4'd2, 16'd0, 16'd2000, 4'd0, 1'b1);
        send_vote(4'd2, 16'd1, 16'd1, 4'd2, 1'b0);
        send_vote(4'd5, 16'hFFFF, 16'd0, 4'd2, 1'b0);
        send_vote(4'd2, 16'd1, 16'd1, 4'd2, 1'b1);
        send_vote(4'd12, 16'd5, 16'd5, 4'd12, 1'b0);
        send_vote(4'd12, 16'd5, 16'd5, 4'd12, 1'b0);
        send_vote(4'd6, 16'hFFFF, 16'hFFFF, 4'd6, 1'b1);
        run_phase(5'd16);

        counts = '{5'd1, 5'd2, 5'd7, 5'd0, 5'd31, 5'd17, 5'($urandom_range(3, 15)), 5'd16};
        foreach (counts[i]) begin
            set_class_count(counts[i]);
            if (i == 0) begin
                send_vote(4'd9, 16'hFFFF, 16'd0, 4'd0, 1'b0);
                send_vote(4'd0, 16'd0, 16'hFFFF, 4'd0, 1'b1);
            end
            run_phase(counts[i]);
        end

        wait_drained();
        $display("Covered %0d member votes and %0d checked pattern verdicts,",
                 votes_sent, verdicts_seen);
        $display("over %0d class-count settings including zero, one, sixteen and out of range.",
                 settings_used);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: ensemble_majority_vote_tiebreak_core.f
rtl/evm_pkg.sv
rtl/evm_if.sv
rtl/evm_store.sv
rtl/evm_unit.sv
rtl/ensemble_majority_vote_tiebreak_core.sv
dv/vote_tally_checker.sv
dv/tb.sv
